### rtl/core/gravity_force_accumulator_unit_defines.svh
// Assertion macros for the RTL of the gravity force accumulator (used by gfa_ctrl).
// Each body expects i_clk and i_rst_n to be in scope where it is used.
`ifndef GRAVITY_FORCE_ACCUMULATOR_UNIT_DEFINES_SVH
`define GRAVITY_FORCE_ACCUMULATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gfa: same-cycle check failed");
`define GFA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gfa: next-cycle check failed");
`else
`define GFA_ASSERT_IMP(lbl, ante, cons)
`define GFA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/core/gfa_pkg.sv
package gfa_pkg;

    localparam int DIMS      = 3;
    localparam int FRAC_BITS = 16;
    localparam int GAIN_FRAC = 16;
    localparam int OUT_FRAC  = 24;
    localparam int SOFT_FRAC = 32;
    localparam int K_SHIFT   = OUT_FRAC - GAIN_FRAC;
    localparam int SOFT_LSH  = (2 * FRAC_BITS >= SOFT_FRAC) ? 2 * FRAC_BITS - SOFT_FRAC : 0;
    localparam int SOFT_RSH  = (2 * FRAC_BITS >= SOFT_FRAC) ? 0 : SOFT_FRAC - 2 * FRAC_BITS;

    localparam int D_W    = 33;
    localparam int R2_W   = 66;
    localparam int P_W    = 200;
    localparam int ROOT_W = 100;
    localparam int REM_W  = 103;
    localparam int K_W    = 104;
    localparam int NUM_W  = 136;
    localparam int Q_W    = 48;
    localparam int CNT_W  = 8;

    localparam logic [CNT_W-1:0] SQ_LEN   = CNT_W'(D_W);
    localparam logic [CNT_W-1:0] R2_LEN   = CNT_W'(R2_W);
    localparam logic [CNT_W-1:0] SQRT_LEN = CNT_W'(P_W / 2);
    localparam logic [CNT_W-1:0] KG_LEN   = CNT_W'(32);
    localparam logic [CNT_W-1:0] DIV_LEN  = CNT_W'(NUM_W);

    localparam logic signed [47:0] SMAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SMIN = 48'sh8000_0000_0000;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT = 1'b1;
    localparam logic [31:0] GAIN_RESET = 32'd65536;
    localparam logic [31:0] SOFT_RESET = 32'd1;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic        [31:0] target_mass;
        logic signed [31:0] source_x;
        logic signed [31:0] source_y;
        logic signed [31:0] source_z;
        logic        [31:0] source_mass;
        logic               last_source;
    } t_in_word;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic               saturated;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SETUP_SQ,
        OP_MAC_STEP,
        OP_SETUP_R2SQ,
        OP_SETUP_R3,
        OP_SETUP_SQRT,
        OP_SQRT_STEP,
        OP_SETUP_KG,
        OP_SETUP_KM,
        OP_SAVE_K,
        OP_SETUP_NUM,
        OP_SETUP_DIV,
        OP_DIV_STEP,
        OP_ACC,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] dim;
    } t_cmd;

    typedef struct packed {
        logic r2_zero;
        logic last;
        logic out_free;
    } t_sts;

endpackage

### rtl/core/gravity_force_accumulator_unit.sv
// Softened direct-sum gravity on one target particle.
// Input channel: i_in_valid, o_in_stall, i_in_data carries one target and one
// source particle per word; last_source closes the sum for that target.
// Output channel: o_out_valid, i_out_stall, o_out_data carries the Q24.24 total
// force and the saturation flag, one word per closed sum.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 gravity gain, 1 softening); the user must write only while the block is
// idle, since the block itself does not enforce it.
// Each input word is processed by one bit-serial multiply-accumulate unit, a
// two-bit-per-cycle square root of r2 cubed and a one-bit-per-cycle divider run
// per dimension; a pair with zero r2 skips the cube, root, division and sum.
// After the last pair the result moves into the output register once it is free.
// A new input word is taken while a result waits; if the receiver still stalls
// when the next closing word is done, the block holds until the register frees.
// Reset, synchronous and active low, clears the accumulators, the flag, the
// output valid flag and restores the gain to 1.0 and the softening to one LSB.
module gravity_force_accumulator_unit import gfa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    gfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gfa_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

### rtl/core/gfa_ctrl.sv
`include "gravity_force_accumulator_unit_defines.svh"

module gfa_ctrl import gfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [19:0] {
        S_IDLE     = 20'h00001,
        S_SQ_SET   = 20'h00002,
        S_SQ_RUN   = 20'h00004,
        S_R2SQ_SET = 20'h00008,
        S_R2SQ_RUN = 20'h00010,
        S_R3_SET   = 20'h00020,
        S_R3_RUN   = 20'h00040,
        S_SQRT_SET = 20'h00080,
        S_SQRT_RUN = 20'h00100,
        S_KG_SET   = 20'h00200,
        S_KG_RUN   = 20'h00400,
        S_KM_SET   = 20'h00800,
        S_KM_RUN   = 20'h01000,
        S_K_SAVE   = 20'h02000,
        S_NUM_SET  = 20'h04000,
        S_NUM_RUN  = 20'h08000,
        S_DIV_SET  = 20'h10000,
        S_DIV_RUN  = 20'h20000,
        S_ACC      = 20'h40000,
        S_FIN      = 20'h80000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_dim, n_dim;
    logic             last_dim;

    assign last_dim   = (r_dim == 2'(DIMS - 1));
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt + 1'b1;
        n_dim     = r_dim;
        o_cmd.op  = OP_NONE;
        o_cmd.dim = r_dim;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_dim    = 2'd0;
                    n_state  = S_SQ_SET;
                end
            end
            S_SQ_SET: begin
                o_cmd.op = OP_SETUP_SQ;
                n_cnt    = '0;
                n_state  = S_SQ_RUN;
            end
            S_SQ_RUN: begin
                o_cmd.op = OP_MAC_STEP;
                if (r_cnt == SQ_LEN - 1'b1) begin
                    if (last_dim) begin
                        n_state = S_R2SQ_SET;
                    end else begin
                        n_dim   = r_dim + 1'b1;
                        n_state = S_SQ_SET;
                    end
                end
            end
            S_R2SQ_SET: begin
                o_cmd.op = OP_SETUP_R2SQ;
                n_cnt    = '0;
                n_state  = i_sts.r2_zero ? S_FIN : S_R2SQ_RUN;
            end
            S_R2SQ_RUN: begin
                o_cmd.op = OP_MAC_STEP;
                if (r_cnt == R2_LEN - 1'b1) begin
                    n_state = S_R3_SET;
                end
            end
            S_R3_SET: begin
                o_cmd.op = OP_SETUP_R3;
                n_cnt    = '0;
                n_state  = S_R3_RUN;
            end
            S_R3_RUN: begin
                o_cmd.op = OP_MAC_STEP;
                if (r_cnt == R2_LEN - 1'b1) begin
                    n_state = S_SQRT_SET;
                end
            end
            S_SQRT_SET: begin
                o_cmd.op = OP_SETUP_SQRT;
                n_cnt    = '0;
                n_state  = S_SQRT_RUN;
            end
            S_SQRT_RUN: begin
                o_cmd.op = OP_SQRT_STEP;
                if (r_cnt == SQRT_LEN - 1'b1) begin
                    n_state = S_KG_SET;
                end
            end
            S_KG_SET: begin
                o_cmd.op = OP_SETUP_KG;
                n_cnt    = '0;
                n_state  = S_KG_RUN;
            end
            S_KG_RUN: begin
                o_cmd.op = OP_MAC_STEP;
                if (r_cnt == KG_LEN - 1'b1) begin
                    n_state = S_KM_SET;
                end
            end
            S_KM_SET: begin
                o_cmd.op = OP_SETUP_KM;
                n_cnt    = '0;
                n_state  = S_KM_RUN;
            end
            S_KM_RUN: begin
                o_cmd.op = OP_MAC_STEP;
                if (r_cnt == KG_LEN - 1'b1) begin
                    n_state = S_K_SAVE;
                end
            end
            S_K_SAVE: begin
                o_cmd.op = OP_SAVE_K;
                n_dim    = 2'd0;
                n_state  = S_NUM_SET;
            end
            S_NUM_SET: begin
                o_cmd.op = OP_SETUP_NUM;
                n_cnt    = '0;
                n_state  = S_NUM_RUN;
            end
            S_NUM_RUN: begin
                o_cmd.op = OP_MAC_STEP;
                if (r_cnt == SQ_LEN - 1'b1) begin
                    n_state = S_DIV_SET;
                end
            end
            S_DIV_SET: begin
                o_cmd.op = OP_SETUP_DIV;
                n_cnt    = '0;
                n_state  = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == DIV_LEN - 1'b1) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                if (last_dim) begin
                    n_state = S_FIN;
                end else begin
                    n_dim   = r_dim + 1'b1;
                    n_state = S_NUM_SET;
                end
            end
            S_FIN: begin
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_dim   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dim   <= n_dim;
        end
    end

    `GFA_ASSERT_IMP(a_emit_needs_room, o_cmd.op == OP_EMIT, i_sts.out_free)
    `GFA_ASSERT_NXT(a_accept_leaves_idle, r_state == S_IDLE && i_in_valid, r_state == S_SQ_SET)
    `GFA_ASSERT_NXT(a_zero_r2_skips, r_state == S_R2SQ_SET && i_sts.r2_zero, r_state == S_FIN)
    `GFA_ASSERT_IMP(a_div_count_bound, r_state == S_DIV_RUN, r_cnt < DIV_LEN)

endmodule

### rtl/core/gfa_dpath.sv
module gfa_dpath import gfa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_in_word             i_in_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output t_out_word            o_out_data,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts
);

    logic [31:0]            r_gain, r_soft;
    logic signed [D_W-1:0]  r_d [0:2];
    logic [31:0]            r_mt, r_ms;
    logic                   r_last;
    logic [P_W-1:0]         r_prod, r_a;
    logic [R2_W-1:0]        r_b, r_r2;
    logic [REM_W-1:0]       r_rem;
    logic [ROOT_W-1:0]      r_root, r_den;
    logic [K_W-1:0]         r_k;
    logic [Q_W-1:0]         r_q;
    logic                   r_big;
    logic signed [47:0]     r_acc [0:2];
    logic                   r_sat;
    logic                   r_out_valid;
    t_out_word              r_out;

    logic [D_W-1:0]         ad;
    logic [R2_W-1:0]        soft_al;
    logic [REM_W-1:0]       sq_rem, sq_trial;
    logic [ROOT_W:0]        dv_rem;
    logic                   dv_ge;
    logic                   over, neg;
    logic signed [47:0]     term;
    logic signed [48:0]     sum;
    logic                   ovf;

    assign ad      = r_d[i_cmd.dim][D_W-1] ? D_W'(-r_d[i_cmd.dim]) : D_W'(r_d[i_cmd.dim]);
    assign soft_al = (R2_W'(r_soft) << SOFT_LSH) >> SOFT_RSH;

    assign sq_rem   = {r_rem[REM_W-3:0], r_prod[P_W-1 -: 2]};
    assign sq_trial = REM_W'({r_root, 2'b01});

    assign dv_rem = {r_rem[ROOT_W-1:0], r_prod[P_W-1]};
    assign dv_ge  = (dv_rem >= {1'b0, r_den});

    assign over = r_big | r_q[Q_W-1];
    assign neg  = r_d[i_cmd.dim][D_W-1];
    always_comb begin
        if (over) begin
            term = neg ? SMIN : SMAX;
        end else if (neg) begin
            term = 48'(-{1'b0, r_q[Q_W-2:0]});
        end else begin
            term = {1'b0, r_q[Q_W-2:0]};
        end
    end
    assign sum = {r_acc[i_cmd.dim][47], r_acc[i_cmd.dim]} + {term[47], term};
    assign ovf = (sum[48] != sum[47]);

    assign o_sts.r2_zero  = (r_prod[R2_W-1:0] == '0);
    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_soft <= SOFT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN: r_gain <= i_cfg_data;
                REG_SOFT: r_soft <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_d[0] <= D_W'(i_in_data.source_x) - D_W'(i_in_data.target_x);
                r_d[1] <= D_W'(i_in_data.source_y) - D_W'(i_in_data.target_y);
                r_d[2] <= D_W'(i_in_data.source_z) - D_W'(i_in_data.target_z);
                r_mt   <= i_in_data.target_mass;
                r_ms   <= i_in_data.source_mass;
                r_last <= i_in_data.last_source;
                r_prod <= P_W'(soft_al);
            end
            OP_SETUP_SQ: begin
                r_a <= P_W'(ad);
                r_b <= R2_W'(ad);
            end
            OP_MAC_STEP: begin
                if (r_b[0]) begin
                    r_prod <= r_prod + r_a;
                end
                r_a <= r_a << 1;
                r_b <= r_b >> 1;
            end
            OP_SETUP_R2SQ: begin
                r_r2   <= r_prod[R2_W-1:0];
                r_a    <= P_W'(r_prod[R2_W-1:0]);
                r_b    <= r_prod[R2_W-1:0];
                r_prod <= '0;
            end
            OP_SETUP_R3: begin
                r_a    <= r_prod;
                r_b    <= r_r2;
                r_prod <= '0;
            end
            OP_SETUP_SQRT: begin
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQRT_STEP: begin
                if (sq_rem >= sq_trial) begin
                    r_rem  <= sq_rem - sq_trial;
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= sq_rem;
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                r_prod <= r_prod << 2;
            end
            OP_SETUP_KG: begin
                r_den  <= r_root;
                r_a    <= P_W'(r_gain);
                r_b    <= R2_W'(r_mt);
                r_prod <= '0;
            end
            OP_SETUP_KM: begin
                r_a    <= P_W'(r_prod[63:0]);
                r_b    <= R2_W'(r_ms);
                r_prod <= '0;
            end
            OP_SAVE_K: begin
                r_k <= {r_prod[K_W-K_SHIFT-1:0], K_SHIFT'(0)};
            end
            OP_SETUP_NUM: begin
                r_a    <= P_W'(r_k);
                r_b    <= R2_W'(ad);
                r_prod <= '0;
            end
            OP_SETUP_DIV: begin
                r_prod <= {r_prod[NUM_W-1:0], (P_W - NUM_W)'(0)};
                r_rem  <= '0;
                r_q    <= '0;
                r_big  <= 1'b0;
            end
            OP_DIV_STEP: begin
                r_rem  <= REM_W'(dv_ge ? dv_rem - {1'b0, r_den} : dv_rem);
                r_q    <= {r_q[Q_W-2:0], dv_ge};
                r_big  <= r_big | r_q[Q_W-1];
                r_prod <= r_prod << 1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_out.force_x   <= r_acc[0];
            r_out.force_y   <= r_acc[1];
            r_out.force_z   <= r_acc[2];
            r_out.saturated <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc[0]    <= '0;
            r_acc[1]    <= '0;
            r_acc[2]    <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_ACC: begin
                    if (ovf) begin
                        r_acc[i_cmd.dim] <= sum[48] ? SMIN : SMAX;
                    end else begin
                        r_acc[i_cmd.dim] <= sum[47:0];
                    end
                    r_sat <= r_sat | over | ovf;
                end
                OP_EMIT: begin
                    r_acc[0] <= '0;
                    r_acc[1] <= '0;
                    r_acc[2] <= '0;
                    r_sat    <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### tb/tb_gravity_force_accumulator_unit.sv
`timescale 1ns / 1ps

module tb_gravity_force_accumulator_unit;
    import gfa_pkg::*;

    localparam longint CYCLE_LIMIT = 12_000_000;
    localparam int     SETTLE_CYCLES = 1200;
    localparam int     PHASE_ITEMS = 340;

    class force_scoreboard;
        logic [31:0] gain;
        logic [31:0] soft_sq;
        longint      acc[3];
        bit          sat;
        t_out_word   expected_forces[$];
        int          mismatches;

        function new();
            gain = GAIN_RESET;
            soft_sq = SOFT_RESET;
            acc[0] = 0;
            acc[1] = 0;
            acc[2] = 0;
            sat = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            if (idx == REG_GAIN) begin
                gain = value;
            end else if (idx == REG_SOFT) begin
                soft_sq = value;
            end
        endfunction

        function void note_input(t_in_word w);
            longint      d[3];
            logic [255:0] mag[3];
            logic [255:0] r2, r3, den, t, k, q;
            longint      term, sum;
            t_out_word   res;
            d[0] = longint'(w.source_x) - longint'(w.target_x);
            d[1] = longint'(w.source_y) - longint'(w.target_y);
            d[2] = longint'(w.source_z) - longint'(w.target_z);
            r2 = (256'(soft_sq) << SOFT_LSH) >> SOFT_RSH;
            for (int i = 0; i < DIMS; i++) begin
                mag[i] = 256'(d[i] < 0 ? -d[i] : d[i]);
                r2 = r2 + mag[i] * mag[i];
            end
            if (r2 != 0) begin
                r3 = r2 * r2 * r2;
                den = 0;
                for (int b = 127; b >= 0; b--) begin
                    t = den;
                    t[b] = 1'b1;
                    if (t * t <= r3) den = t;
                end
                if (den == 0) den = 1;
                k = (256'(gain) * 256'(w.target_mass) * 256'(w.source_mass)) << K_SHIFT;
                for (int i = 0; i < DIMS; i++) begin
                    q = (k * mag[i]) / den;
                    if (q[255:47] != 0) begin
                        sat = 1;
                        term = d[i] < 0 ? longint'(SMIN) : longint'(SMAX);
                    end else begin
                        term = d[i] < 0 ? -longint'(q[46:0]) : longint'(q[46:0]);
                    end
                    sum = acc[i] + term;
                    if (sum > longint'(SMAX)) begin
                        sum = SMAX;
                        sat = 1;
                    end else if (sum < longint'(SMIN)) begin
                        sum = SMIN;
                        sat = 1;
                    end
                    acc[i] = sum;
                end
            end
            if (w.last_source) begin
                res.force_x = acc[0][47:0];
                res.force_y = acc[1][47:0];
                res.force_z = acc[2][47:0];
                res.saturated = sat;
                expected_forces.insert(expected_forces.size(), res);
                acc[0] = 0;
                acc[1] = 0;
                acc[2] = 0;
                sat = 0;
            end
        endfunction

        function void check(t_out_word got);
            t_out_word want;
            if (expected_forces.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected force word %h", got);
                return;
            end
            want = expected_forces.pop_front();
            if (got.force_x !== want.force_x || got.force_y !== want.force_y ||
                got.force_z !== want.force_z || got.saturated !== want.saturated) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("force mismatch: expected x=%h y=%h z=%h sat=%b",
                             want.force_x, want.force_y, want.force_z, want.saturated);
                    $display("                actual   x=%h y=%h z=%h sat=%b",
                             got.force_x, got.force_y, got.force_z, got.saturated);
                end
            end
        endfunction
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_in_valid = 0;
    logic                 o_in_stall;
    t_in_word             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 0;
    t_out_word            o_out_data;
    logic                 i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0]          i_cfg_data = '0;

    force_scoreboard sb = new();
    longint          cycles = 0;
    bit              no_idle = 0;

    gravity_force_accumulator_unit u_top (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check(o_out_data);
    end

    initial begin
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = no_idle ? 0 : $urandom_range(13, 0);
            if (n > 0) begin
                i_out_stall <= 1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_pair(t_in_word w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(13, 0);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(w);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.expected_forces.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, value);
    endtask

    function automatic logic [31:0] near(logic [31:0] base);
        case ($urandom_range(3, 0))
            0: return $urandom();
            1: return base + 32'($signed($urandom_range(2047, 0)) - 1024);
            default: return base + 32'($signed($urandom_range(1 << 21, 0)) - (1 << 20));
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(3, 0))
            0: return $urandom();
            1: return $urandom_range(32'h0010_0000, 0);
            default: return $urandom_range(32'h0002_0000, 32'h0000_4000);
        endcase
    endfunction

    task automatic random_phase(int count);
        t_in_word w;
        w = '0;
        w.target_x = $urandom();
        w.target_y = $urandom();
        w.target_z = $urandom();
        w.target_mass = rand_mass();
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9, 0) == 0) begin
                w.target_x = $urandom();
                w.target_y = $urandom();
                w.target_z = $urandom();
                w.target_mass = rand_mass();
            end
            if ($urandom_range(9, 0) == 0) begin
                w.source_x = w.target_x;
                w.source_y = w.target_y;
                w.source_z = w.target_z;
            end else begin
                w.source_x = near(w.target_x);
                w.source_y = near(w.target_y);
                w.source_z = near(w.target_z);
            end
            w.source_mass = rand_mass();
            w.last_source = ($urandom_range(3, 0) == 0);
            send_pair(w);
            if (w.last_source) begin
                w.target_x = $urandom();
                w.target_y = $urandom();
                w.target_z = $urandom();
                w.target_mass = rand_mass();
            end
        end
        w.last_source = 1;
        send_pair(w);
    endtask

    task automatic directed();
        t_in_word w;
        w = '0;
        w.target_mass = 32'h0001_0000;
        w.source_mass = 32'h0001_0000;
        w.last_source = 1;
        send_pair(w);
        w.source_x = 32'sh0001_0000;
        send_pair(w);
        w.source_x = 0;
        w.source_y = -32'sh0002_0000;
        w.source_z = 32'sh0000_8000;
        w.last_source = 0;
        send_pair(w);
        w.last_source = 1;
        send_pair(w);
        w.target_x = 32'sh7FFF_FFFF;
        w.target_y = 32'sh8000_0000;
        w.target_z = 32'sh7FFF_FFFF;
        w.source_x = 32'sh8000_0000;
        w.source_y = 32'sh7FFF_FFFF;
        w.source_z = 32'sh8000_0000;
        w.target_mass = '1;
        w.source_mass = '1;
        send_pair(w);
        w.target_x = 0;
        w.target_y = 0;
        w.target_z = 0;
        w.source_x = 1;
        w.source_y = -1;
        w.source_z = 1;
        send_pair(w);
        for (int i = 0; i < 4; i++) begin
            w.last_source = (i == 3);
            send_pair(w);
        end
        w.target_mass = 0;
        send_pair(w);
        w.target_mass = '1;
        w.source_mass = 0;
        send_pair(w);
        w.source_mass = '1;
        w.source_x = 0;
        w.source_y = 0;
        w.source_z = 0;
        send_pair(w);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        directed();
        random_phase(PHASE_ITEMS);
        drain();
        write_reg(REG_GAIN, 32'd0);
        write_reg(REG_SOFT, 32'd0);
        directed();
        no_idle = 1;
        random_phase(PHASE_ITEMS / 2);
        no_idle = 0;
        drain();
        write_reg(REG_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_SOFT, 32'hFFFF_FFFF);
        directed();
        random_phase(PHASE_ITEMS);
        drain();
        write_reg(REG_GAIN, $urandom_range(32'h0004_0000, 32'h0000_0100));
        write_reg(REG_SOFT, $urandom());
        random_phase(PHASE_ITEMS);
        drain();
        write_reg(REG_GAIN, 32'd1);
        write_reg(REG_SOFT, 32'd0);
        directed();
        random_phase(PHASE_ITEMS / 2);
        drain();
        write_reg(REG_GAIN, GAIN_RESET);
        write_reg(REG_SOFT, SOFT_RESET);
        random_phase(PHASE_ITEMS / 2);
        drain();
        if (sb.mismatches == 0 && sb.expected_forces.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
